### rtl/core/cbp_pkg.sv
// Package for the contour block packer: field widths, default sizes and the
// command and status bundles between the controller and the datapath.
// Depends on nothing; every other file of the block uses it.
package cbp_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int MAX_BLOCKS_DEF  = 256;
  localparam int CONTOUR_LEN_DEF = 1024;

  // Fixed field widths.
  localparam int IDX_W = 8;
  localparam int XW    = 11;
  localparam int WW    = 10;
  localparam int HW    = 10;
  localparam int YW    = 16;

  // Width of the generation tag kept with every contour column.
  localparam int EPOCH_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic calc_x;
    logic clear_start;
    logic clear_step;
    logic setup;
    logic scan_step;
    logic calc_top;
    logic write_step;
    logic load_out;
  } cbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root;
    logic epoch_full;
    logic clear_last;
    logic scan_done;
    logic write_done;
  } cbp_status_t;

endpackage

### rtl/core/cbp_ctrl.sv
// Controller of the contour block packer: the sequencing state machine and
// the output valid flag. Depends on cbp_pkg for the command and status types.
module cbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cbp_pkg::cbp_status_t status,
  output cbp_pkg::cbp_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_SETUP = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_TOP   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   clear_resume;
  logic   clear_resume_next;
  logic   out_valid_next;

  // Next state and command decode.
  always_comb begin
    state_next        = state;
    clear_resume_next = clear_resume;
    cmd               = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next        = clear_resume ? S_SETUP : S_IDLE;
          clear_resume_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.calc_x = 1'b1;
        // A root that finds every tag value used must wipe the contour first.
        if (status.root && status.epoch_full) begin
          cmd.clear_start   = 1'b1;
          clear_resume_next = 1'b1;
          state_next        = S_CLEAR;
        end else begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        cmd.calc_top = 1'b1;
        state_next   = S_WRITE;
      end
      S_WRITE: begin
        if (status.write_done) begin
          state_next = S_DONE;
        end else begin
          cmd.write_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // The output register is refilled in the same cycle that it is emptied.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_resume <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      clear_resume <= clear_resume_next;
      out_valid    <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

### rtl/core/cbp_datapath.sv
// Datapath of the contour block packer: block position stores, the tagged
// contour memory, the column pointer, the running maximum and the output
// register. Depends on cbp_pkg; driven by cbp_ctrl.
module cbp_datapath #(
  parameter int MAX_BLOCKS  = cbp_pkg::MAX_BLOCKS_DEF,
  parameter int CONTOUR_LEN = cbp_pkg::CONTOUR_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cbp_pkg::IDX_W-1:0]     block_index,
  input  logic [cbp_pkg::IDX_W-1:0]     parent_index,
  input  logic                          first_block,
  input  logic                          left_branch,
  input  logic [cbp_pkg::WW-1:0]        block_width,
  input  logic [cbp_pkg::HW-1:0]        block_height,
  input  cbp_pkg::cbp_cmd_t             cmd,
  output cbp_pkg::cbp_status_t          status,
  output logic [cbp_pkg::XW-1:0]        place_x,
  output logic [cbp_pkg::YW-1:0]        place_y,
  output logic                          overflow
);

  localparam int XW  = cbp_pkg::XW;
  localparam int WW  = cbp_pkg::WW;
  localparam int HW  = cbp_pkg::HW;
  localparam int YW  = cbp_pkg::YW;
  localparam int EW  = cbp_pkg::EPOCH_W;
  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(CONTOUR_LEN);
  localparam int PW  = (CW + 1 > XW + 1) ? CW + 1 : XW + 1;
  localparam int SW  = EW + YW;

  // Reduces an index modulo the store depth by restoring subtraction.
  function automatic logic [BW-1:0] wrap_index(input logic [cbp_pkg::IDX_W-1:0] v);
    int r;
    r = int'(v);
    for (int k = cbp_pkg::IDX_W - 1; k >= 0; k--) begin
      if ((r >> k) >= MAX_BLOCKS) begin
        r = r - (MAX_BLOCKS << k);
      end
    end
    return BW'(r);
  endfunction

  // Stores of placed blocks.
  logic [XW-1:0] xs_mem [MAX_BLOCKS];
  logic [WW-1:0] ws_mem [MAX_BLOCKS];

  // Contour: a generation tag and a height for every column.
  logic [SW-1:0] sky_mem [CONTOUR_LEN];

  logic          root_r;
  logic          left_r;
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [BW-1:0] bidx_r;
  logic [XW-1:0] px_r;
  logic [WW-1:0] pw_r;
  logic [XW-1:0] x_r;
  logic          ovf_r;
  logic [PW-1:0] end_r;
  logic [PW-1:0] ptr;
  logic          rd_pending;
  logic [SW-1:0] sky_rd;
  logic [YW-1:0] ymax;
  logic [YW-1:0] top_r;
  logic [EW-1:0] epoch;

  logic [XW:0]   x_sum;
  logic          x_sat;
  logic [XW-1:0] x_calc;
  logic          x_ovf;
  logic [XW:0]   end_sum;
  logic          end_over;
  logic [YW:0]   top_sum;
  logic          top_sat;
  logic          in_range;
  logic [YW-1:0] rd_y;
  logic          sky_we;
  logic [SW-1:0] sky_wdata;
  logic [CW-1:0] ptr_idx;

  // Child position from the parent entry, saturated at the top of the x range.
  assign x_sum  = {1'b0, px_r} + {{(XW + 1 - WW){1'b0}}, pw_r};
  assign x_sat  = x_sum[XW];
  assign x_ovf  = !root_r && left_r && x_sat;
  always_comb begin
    if (root_r) begin
      x_calc = '0;
    end else if (left_r) begin
      x_calc = x_sat ? {XW{1'b1}} : x_sum[XW-1:0];
    end else begin
      x_calc = px_r;
    end
  end

  // Right edge of the block, clipped to the contour length.
  assign end_sum  = {1'b0, x_r} + {{(XW + 1 - WW){1'b0}}, w_r};
  assign end_over = 32'(end_sum) > 32'(CONTOUR_LEN);

  // Top of the block, saturated at the y range.
  assign top_sum = {1'b0, ymax} + {{(YW + 1 - HW){1'b0}}, h_r};
  assign top_sat = top_sum[YW];

  assign in_range = ptr < end_r;
  assign ptr_idx  = ptr[CW-1:0];

  // A column written under an older tag reads as empty.
  assign rd_y = (sky_rd[SW-1:YW] == epoch) ? sky_rd[YW-1:0] : '0;

  assign sky_we    = cmd.clear_step || (cmd.write_step && in_range);
  assign sky_wdata = cmd.clear_step ? '0 : {epoch, top_r};

  // Block store ports: parent read on acceptance, own entry written at setup.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      xs_mem[bidx_r] <= x_r;
      ws_mem[bidx_r] <= w_r;
    end
    if (cmd.load_item) begin
      px_r <= xs_mem[wrap_index(parent_index)];
      pw_r <= ws_mem[wrap_index(parent_index)];
    end
  end

  // Contour memory ports.
  always_ff @(posedge clk) begin
    if (sky_we) begin
      sky_mem[ptr_idx] <= sky_wdata;
    end
    if (cmd.scan_step && in_range) begin
      sky_rd <= sky_mem[ptr_idx];
    end
  end

  // Column pointer, read tracking and generation tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      rd_pending <= 1'b0;
      epoch      <= '0;
    end else begin
      if (cmd.clear_start) begin
        ptr <= '0;
      end
      if (cmd.clear_step) begin
        if (status.clear_last) begin
          ptr   <= '0;
          epoch <= '0;
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      if (cmd.calc_x && root_r && !status.epoch_full) begin
        epoch <= epoch + 1'b1;
      end
      if (cmd.setup || cmd.calc_top) begin
        ptr <= {{(PW - XW){1'b0}}, x_r};
      end
      if (cmd.scan_step) begin
        rd_pending <= in_range;
        if (in_range) begin
          ptr <= ptr + 1'b1;
        end
      end
      if (cmd.write_step && in_range) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // Item fields, position, running maximum and overflow.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      root_r <= first_block;
      left_r <= left_branch;
      w_r    <= block_width;
      h_r    <= block_height;
      bidx_r <= wrap_index(block_index);
    end
    if (cmd.calc_x) begin
      x_r   <= x_calc;
      ovf_r <= x_ovf;
    end
    if (cmd.setup) begin
      end_r <= end_over ? PW'(CONTOUR_LEN) : PW'(end_sum);
      ymax  <= '0;
      if (end_over) begin
        ovf_r <= 1'b1;
      end
    end
    if (cmd.scan_step && rd_pending && (rd_y > ymax)) begin
      ymax <= rd_y;
    end
    if (cmd.calc_top) begin
      top_r <= top_sat ? {YW{1'b1}} : top_sum[YW-1:0];
      if (top_sat) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      place_x  <= x_r;
      place_y  <= ymax;
      overflow <= ovf_r;
    end
  end

  assign status.root       = root_r;
  assign status.epoch_full = &epoch;
  assign status.clear_last = (ptr == PW'(CONTOUR_LEN - 1));
  assign status.scan_done  = !in_range && !rd_pending;
  assign status.write_done = !in_range;

endmodule

### rtl/core/contour_block_packer_top.sv
// Contour block packer: places rectangular blocks of a floorplan tree over a
// column contour, one block per transaction on the input channel.
//
// Input channel (in_valid/in_ready) carries one block in tree preorder: its
// index, its parent's index, the root and left child flags, width and height.
// Output channel (out_valid/out_ready) returns place_x, place_y and overflow,
// one result transaction per input transaction, in order.
// The block works on one item at a time: the next item is accepted only once
// the result of the last one has been registered. The contour memory has one
// read port and one write port, and every covered column is read once to find
// the height and written once to raise it.
// Every 256th root wipes the contour first, since the generation tag that
// empties the contour at each root has 8 bits.
// After reset the contour is wiped, which holds in_ready low until the wipe
// is done; the block position stores are not cleared.
// A finished result waits in the output register while the next item is
// accepted and worked on; if the receiver still stalls when that item is
// done, the block waits and in_ready stays low.
// Depends on cbp_pkg, cbp_ctrl and cbp_datapath.
module contour_block_packer_top #(
  parameter int MAX_BLOCKS  = cbp_pkg::MAX_BLOCKS_DEF,
  parameter int CONTOUR_LEN = cbp_pkg::CONTOUR_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cbp_pkg::IDX_W-1:0] block_index,
  input  logic [cbp_pkg::IDX_W-1:0] parent_index,
  input  logic                      first_block,
  input  logic                      left_branch,
  input  logic [cbp_pkg::WW-1:0]    block_width,
  input  logic [cbp_pkg::HW-1:0]    block_height,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cbp_pkg::XW-1:0]    place_x,
  output logic [cbp_pkg::YW-1:0]    place_y,
  output logic                      overflow
);

  cbp_pkg::cbp_cmd_t    cmd;
  cbp_pkg::cbp_status_t status;

  // Sequencer.
  cbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Stores, contour memory and arithmetic.
  cbp_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .CONTOUR_LEN (CONTOUR_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .block_index  (block_index),
    .parent_index (parent_index),
    .first_block  (first_block),
    .left_branch  (left_branch),
    .block_width  (block_width),
    .block_height (block_height),
    .cmd          (cmd),
    .status       (status),
    .place_x      (place_x),
    .place_y      (place_y),
    .overflow     (overflow)
  );

endmodule

### rtl/core/cbp_checker.sv
// Port-level checks for the contour block packer, bound to the top level.
// Depends on cbp_pkg for field widths.
module cbp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [cbp_pkg::XW-1:0]    place_x,
  input logic [cbp_pkg::YW-1:0]    place_y,
  input logic                      overflow
);

  // The contour wipe after reset keeps the input closed.
  a_wipe_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input opened during the contour wipe after reset");

  // An accepted transaction keeps the input closed through S_FETCH and the state after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input reopened too early after a transaction");

  // A new result only appears while the block is busy with an item.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in progress");

  // A stalled result holds its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(place_x) && $stable(place_y) && $stable(overflow)))
    else $error("stalled result changed or dropped");

endmodule

bind contour_block_packer_top cbp_checker u_cbp_checker (.*);

### verif/tb_contour_block_packer_top.sv
// Self-checking testbench for contour_block_packer_top: drives floorplan trees in preorder,
// predicts every placement internally and checks each result transaction in order.
// Depends on cbp_pkg and the contour_block_packer_top RTL.
module tb_contour_block_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = cbp_pkg::IDX_W;
  localparam int XW    = cbp_pkg::XW;
  localparam int WW    = cbp_pkg::WW;
  localparam int HW    = cbp_pkg::HW;
  localparam int YW    = cbp_pkg::YW;

  localparam int NUM_BLOCKS   = cbp_pkg::MAX_BLOCKS_DEF;
  localparam int NUM_COLUMNS  = cbp_pkg::CONTOUR_LEN_DEF;
  localparam int unsigned X_SAT = 2047;
  localparam int unsigned Y_SAT = 65535;
  // Quiet cycles after the last result, longer than the widest item takes.
  localparam int DRAIN_CYCLES = 2 * NUM_COLUMNS + 64;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int MAX_REPORTS  = 10;

  // One expected placement.
  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          ovf;
  } placement_t;

  // One open node on the preorder path of a tree being generated.
  typedef struct {
    logic [IDX_W-1:0] idx;
    bit               left_free;
  } open_node_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [IDX_W-1:0]  block_index;
  logic [IDX_W-1:0]  parent_index;
  logic              first_block;
  logic              left_branch;
  logic [WW-1:0]     block_width;
  logic [HW-1:0]     block_height;
  logic              out_valid;
  logic              out_ready;
  logic [XW-1:0]     place_x;
  logic [YW-1:0]     place_y;
  logic              overflow;

  // Shadow copy of the block state.
  logic [XW-1:0]     shadow_x [NUM_BLOCKS];
  logic [WW-1:0]     shadow_w [NUM_BLOCKS];
  bit                shadow_known [NUM_BLOCKS];
  logic [YW-1:0]     shadow_skyline [NUM_COLUMNS];

  placement_t        pending_placements [$];

  bit                no_idle;
  longint            cycle_count;
  int                mismatches;
  int                blocks_sent;
  int                roots_sent;
  int                results_checked;
  int                overflows_seen;

  contour_block_packer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .block_index  (block_index),
    .parent_index (parent_index),
    .first_block  (first_block),
    .left_branch  (left_branch),
    .block_width  (block_width),
    .block_height (block_height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .place_x      (place_x),
    .place_y      (place_y),
    .overflow     (overflow)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Placement predictor: updates the shadow state and returns the expected result.
  function automatic placement_t place_block(input logic [IDX_W-1:0] bidx,
                                             input logic [IDX_W-1:0] pidx,
                                             input logic root, input logic left,
                                             input logic [WW-1:0] w,
                                             input logic [HW-1:0] h);
    int unsigned x;
    int unsigned y;
    int unsigned top;
    int unsigned last;
    int unsigned i;
    placement_t  r;
    x = 0;
    y = 0;
    r.ovf = 1'b0;
    if (root) begin
      for (i = 0; i < NUM_COLUMNS; i++) shadow_skyline[i] = '0;
    end else begin
      x = shadow_x[pidx];
      if (left) x = x + shadow_w[pidx];
      if (x > X_SAT) begin
        x = X_SAT;
        r.ovf = 1'b1;
      end
    end
    // Columns past the contour are neither read nor written.
    last = x + w;
    if (last > NUM_COLUMNS) begin
      last = NUM_COLUMNS;
      r.ovf = 1'b1;
    end
    for (i = x; i < last; i++) begin
      if (shadow_skyline[i] > y) y = shadow_skyline[i];
    end
    top = y + h;
    if (top > Y_SAT) begin
      top = Y_SAT;
      r.ovf = 1'b1;
    end
    for (i = x; i < last; i++) shadow_skyline[i] = top[YW-1:0];
    // The parent entry has already been read, so a block may name itself as parent.
    shadow_x[bidx] = x[XW-1:0];
    shadow_w[bidx] = w;
    shadow_known[bidx] = 1'b1;
    r.x = x[XW-1:0];
    r.y = y[YW-1:0];
    return r;
  endfunction

  // Mostly narrow blocks keep the run short; a few span most of the contour.
  function automatic logic [WW-1:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return WW'($urandom_range(1, 16));
    else if (sel < 95) return WW'($urandom_range(17, 128));
    else return WW'($urandom_range(129, 1023));
  endfunction

  function automatic logic [HW-1:0] pick_height();
    if ($urandom_range(0, 1) == 0) return HW'($urandom_range(1, 64));
    else return HW'($urandom_range(1, 1023));
  endfunction

  // Any index that already holds a position may serve as a parent.
  function automatic logic [IDX_W-1:0] pick_known_index();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    while (!shadow_known[idx]) idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    return idx;
  endfunction

  // Send one block as an input transaction and record its expected placement.
  task automatic send_block(input logic [IDX_W-1:0] bidx, input logic [IDX_W-1:0] pidx,
                            input logic root, input logic left,
                            input logic [WW-1:0] w, input logic [HW-1:0] h);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    block_index  <= bidx;
    parent_index <= pidx;
    first_block  <= root;
    left_branch  <= left;
    block_width  <= w;
    block_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_placements.push_back(place_block(bidx, pidx, root, left, w, h));
    blocks_sent++;
    if (root) roots_sent++;
  endtask

  // Build one random tree in preorder; indices run on from a random base.
  task automatic send_tree(input int unsigned nodes);
    open_node_t       path [$];
    open_node_t       node;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx;
    int unsigned      d;
    int unsigned      k;
    base = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
    send_block(base, IDX_W'($urandom), 1'b1, 1'($urandom), pick_width(), pick_height());
    node.idx = base;
    node.left_free = 1'b1;
    path.push_back(node);
    for (k = 1; k < nodes; k++) begin
      // Prefer the deepest open node; otherwise close the subtrees below a random one.
      if ($urandom_range(0, 1) == 0) d = path.size() - 1;
      else d = $urandom_range(0, path.size() - 1);
      while (path.size() > d + 1) void'(path.pop_back());
      idx = base + IDX_W'(k);
      if (path[d].left_free && $urandom_range(0, 1) == 0) begin
        send_block(idx, path[d].idx, 1'b0, 1'b1, pick_width(), pick_height());
        path[d].left_free = 1'b0;
      end else begin
        // A right child closes its parent completely.
        send_block(idx, path[d].idx, 1'b0, 1'b0, pick_width(), pick_height());
        void'(path.pop_back());
      end
      node.idx = idx;
      node.left_free = 1'b1;
      path.push_back(node);
    end
  endtask

  // Unstructured items: any known parent, any flags, self-parenting and stray roots.
  task automatic send_noise(input int unsigned count);
    logic [IDX_W-1:0] pidx;
    logic [IDX_W-1:0] bidx;
    int unsigned      k;
    for (k = 0; k < count; k++) begin
      pidx = pick_known_index();
      bidx = ($urandom_range(0, 3) == 0) ? pidx : IDX_W'($urandom);
      send_block(bidx, pidx, 1'($urandom_range(0, 5) == 0), 1'($urandom),
                 pick_width(), pick_height());
    end
  endtask

  // Edge positions, contour end, x saturation, self-parenting and root clearing.
  task automatic test_directed();
    send_block(8'd0,   8'd255, 1'b1, 1'b1, 10'd1,    10'd1);
    send_block(8'd255, 8'd0,   1'b1, 1'b0, 10'd1023, 10'd1023);
    send_block(8'd1,   8'd255, 1'b0, 1'b1, 10'd1,    10'd1);
    send_block(8'd2,   8'd1,   1'b0, 1'b1, 10'd1023, 10'd1023);
    send_block(8'd3,   8'd2,   1'b0, 1'b1, 10'd1023, 10'd1);
    send_block(8'd4,   8'd3,   1'b0, 1'b1, 10'd16,   10'd1);
    send_block(8'd5,   8'd4,   1'b0, 1'b0, 10'd1,    10'd1);
    send_block(8'd1,   8'd1,   1'b0, 1'b0, 10'd4,    10'd2);
    send_block(8'd6,   8'd255, 1'b0, 1'b0, 10'd1023, 10'd1023);
    send_block(8'd7,   8'd0,   1'b0, 1'b1, 10'd1,    10'd1);
    send_block(8'd8,   8'd7,   1'b1, 1'b0, 10'd3,    10'd7);
    send_block(8'd9,   8'd8,   1'b0, 1'b0, 10'd3,    10'd1);
    send_block(8'd10,  8'd9,   1'b0, 1'b1, 10'd1,    10'd1);
    send_block(8'd128, 8'd10,  1'b0, 1'b0, 10'd512,  10'd512);
    send_block(8'd127, 8'd128, 1'b0, 1'b1, 10'd1,    10'd1023);
    send_block(8'd255, 8'd127, 1'b0, 1'b0, 10'd1023, 10'd1);
  endtask

  // Stacks of right children on narrow columns until the top saturates.
  task automatic test_tall_stacks(input int unsigned stacks);
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] idx;
    int unsigned      s;
    int unsigned      after_sat;
    for (s = 0; s < stacks; s++) begin
      prev = IDX_W'($urandom);
      send_block(prev, IDX_W'($urandom), 1'b1, 1'($urandom), WW'($urandom_range(1, 8)),
                 10'd1023);
      after_sat = 0;
      while (after_sat < 4) begin
        idx = prev + 8'd1;
        send_block(idx, prev, 1'b0, 1'b0, WW'($urandom_range(1, 8)),
                   HW'($urandom_range(900, 1023)));
        if (pending_placements.size() > 0 && pending_placements[$].ovf) after_sat++;
        prev = idx;
      end
    end
  endtask

  // Random trees mixed with noise until the item budget is spent.
  task automatic test_random_trees(input int unsigned budget);
    int unsigned start;
    start = blocks_sent;
    while (blocks_sent - start < budget) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 5));
      else send_tree($urandom_range(2, 40));
    end
  endtask

  // Final stretch with both sides always ready.
  task automatic test_back_to_back(input int unsigned budget);
    no_idle = 1'b1;
    test_random_trees(budget);
  endtask

  // Receiver: random stall bursts, none once the steady phase begins.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (no_idle) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Check every result transaction against the oldest expected placement.
  always @(posedge clk) begin
    placement_t exp_p;
    if (!rst && out_valid && out_ready) begin
      if (pending_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no block outstanding: x=%0d y=%0d ovf=%0b",
                   $realtime, place_x, place_y, overflow);
      end else begin
        exp_p = pending_placements.pop_front();
        results_checked++;
        if (overflow === 1'b1) overflows_seen++;
        if (place_x !== exp_p.x || place_y !== exp_p.y || overflow !== exp_p.ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                     $realtime, exp_p.x, exp_p.y, exp_p.ovf, place_x, place_y, overflow);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_contour_block_packer_top failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    block_index  = '0;
    parent_index = '0;
    first_block  = 1'b0;
    left_branch  = 1'b0;
    block_width  = '0;
    block_height = '0;
    no_idle      = 1'b0;
    cycle_count  = 0;
    mismatches   = 0;
    blocks_sent  = 0;
    roots_sent   = 0;
    results_checked = 0;
    overflows_seen  = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) shadow_known[i] = 1'b0;
    for (int i = 0; i < NUM_COLUMNS; i++) shadow_skyline[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_tall_stacks(2);
    test_random_trees(700);
    test_back_to_back(150);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Placed %0d blocks (%0d roots), checked %0d results, %0d with overflow.",
             blocks_sent, roots_sent, results_checked, overflows_seen);
    $display("Mismatches: %0d over %0d cycles.", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("tb_contour_block_packer_top passed");
    end else begin
      $display("tb_contour_block_packer_top failed");
    end
    $finish;
  end

endmodule
